// File: sv/ffaa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the first-fit arena allocator.
// Depends on nothing; the top, the cell and the testbench use it.
package ffaa_pkg;

   localparam int ARENA_BYTES_DEF  = 4096;
   localparam int HEADER_BYTES_DEF = 8;
   localparam int MIN_SPLIT_DEF    = 8;
   localparam int MAX_SEGMENTS_DEF = 64;

   localparam int SEG_W = 17;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_SIZE = 3'd1;
   localparam logic [2:0] ST_NO_FIT   = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_UNKNOWN  = 3'd4;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [2:0] {
      CELL_NONE,
      CELL_SPLIT,
      CELL_TAKE,
      CELL_MARK,
      CELL_MERGE_RIGHT,
      CELL_MERGE_LEFT
   } cell_cmd_type;

   typedef struct packed {
      logic             valid;
      logic             free;
      logic [SEG_W-1:0] start;
      logic [SEG_W-1:0] size;
   } seg_type;

   typedef struct packed {
      logic             act;
      logic             search;
      logic             found;
      logic             just;
      logic             prev_free;
      logic             lf;
      logic             rf;
      logic [SEG_W-1:0] start;
      logic [SEG_W-1:0] size;
   } pkt_type;

   typedef struct packed {
      cell_cmd_type     cmd;
      logic             is_free;
      logic [SEG_W-1:0] req;
      logic [11:0]      off;
      logic [SEG_W-1:0] nstart;
      logic [SEG_W-1:0] nsize;
   } bcast_type;

endpackage

// File: sv/ffaa_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the arena allocator.
// Depends on nothing.
interface ffaa_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [15:0] request_size;
   logic [11:0] block_offset;
   modport source (output valid, cmd, request_size, block_offset, input ready);
   modport sink (input valid, cmd, request_size, block_offset, output ready);
endinterface

interface ffaa_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [11:0] payload_offset;
   modport source (output valid, status, payload_offset, input ready);
   modport sink (input valid, status, payload_offset, output ready);
endinterface

// File: sv/first_fit_arena_allocator_top.sv
`timescale 1ns / 1ps
// Top level of the first-fit arena allocator: controller and segment chain.
// Depends on ffaa_pkg, ffaa_if and ffaa_cell.
//
//   channel   direction   role
//   req_bus   in          allocate or free transaction
//   rsp_bus   out         status and payload offset, one per transaction
//
// A transaction whose size is bad, or a free of offset zero, answers in the cycle
// after it is taken. Otherwise a search packet walks the chain of MAX_SEGMENTS
// cells, one cell a cycle, and the response is registered in FINISH once the
// packet leaves the last cell; a freed segment that merges with its left neighbor
// passes through STEP2 before FINISH. Reset is synchronous and restores one free
// segment over the arena. A new transaction is taken only once the previous
// response has been taken.
module first_fit_arena_allocator_top #(
   parameter int ARENA_BYTES  = ffaa_pkg::ARENA_BYTES_DEF,
   parameter int HEADER_BYTES = ffaa_pkg::HEADER_BYTES_DEF,
   parameter int MIN_SPLIT    = ffaa_pkg::MIN_SPLIT_DEF,
   parameter int MAX_SEGMENTS = ffaa_pkg::MAX_SEGMENTS_DEF
) (
   input logic         clock,
   input logic         reset,
   ffaa_req_if.sink    req_bus,
   ffaa_rsp_if.source  rsp_bus
);

   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int W = ffaa_pkg::SEG_W;

   typedef enum logic [1:0] {IDLE, SCAN, STEP2, FINISH} state_type;

   state_type           state_ff;
   ffaa_pkg::bcast_type bcast_ff;
   logic [CW-1:0]       count_ff;
   logic                inject_ff;
   logic                rsp_valid_ff;
   logic [2:0]          status_ff;
   logic [11:0]         payload_ff;

   ffaa_pkg::pkt_type pkt_w [0:MAX_SEGMENTS];
   ffaa_pkg::seg_type seg_w [0:MAX_SEGMENTS-1];
   logic              sel_w [0:MAX_SEGMENTS-1];

   ffaa_pkg::pkt_type last_pkt;
   logic [W:0]        split_need;
   logic              accept;

   always_comb begin
      pkt_w[0] = '0;
      pkt_w[0].act = inject_ff;
      pkt_w[0].search = inject_ff;
   end

   for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
      ffaa_pkg::seg_type lseg, rseg;
      logic              lsel, rsel;
      if (k == 0) begin : g_l0
         assign lseg = '0;
         assign lsel = 1'b0;
      end else begin : g_l
         assign lseg = seg_w[k-1];
         assign lsel = sel_w[k-1];
      end
      if (k == MAX_SEGMENTS - 1) begin : g_r0
         assign rseg = '0;
         assign rsel = 1'b0;
      end else begin : g_r
         assign rseg = seg_w[k+1];
         assign rsel = sel_w[k+1];
      end
      ffaa_cell #(
         .IS_HEAD      (k == 0),
         .ARENA_BYTES  (ARENA_BYTES),
         .HEADER_BYTES (HEADER_BYTES)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .bcast     (bcast_ff),
         .pkt_in    (pkt_w[k]),
         .pkt_out   (pkt_w[k+1]),
         .left_seg  (lseg),
         .left_sel  (lsel),
         .right_seg (rseg),
         .right_sel (rsel),
         .seg_out   (seg_w[k]),
         .sel_out   (sel_w[k])
      );
   end

   assign last_pkt = pkt_w[MAX_SEGMENTS];
   assign split_need = {1'b0, bcast_ff.req} + (W+1)'(HEADER_BYTES) + (W+1)'(MIN_SPLIT);
   assign accept = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == IDLE) && !rsp_valid_ff;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.status = status_ff;
   assign rsp_bus.payload_offset = payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         bcast_ff <= '0;
         count_ff <= CW'(1);
         inject_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         status_ff <= ffaa_pkg::ST_OK;
         payload_ff <= '0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               bcast_ff.cmd <= ffaa_pkg::CELL_NONE;
               if (accept) begin
                  bcast_ff.is_free <= req_bus.cmd;
                  bcast_ff.req <= W'(req_bus.request_size);
                  bcast_ff.off <= req_bus.block_offset;
                  payload_ff <= '0;
                  if (req_bus.cmd == ffaa_pkg::CMD_ALLOC &&
                      (req_bus.request_size == '0 ||
                       W'(req_bus.request_size) > W'(ARENA_BYTES))) begin
                     status_ff <= ffaa_pkg::ST_BAD_SIZE;
                     rsp_valid_ff <= 1'b1;
                     inject_ff <= 1'b0;
                  end else if (req_bus.cmd == ffaa_pkg::CMD_FREE &&
                               req_bus.block_offset == '0) begin
                     status_ff <= ffaa_pkg::ST_OK;
                     rsp_valid_ff <= 1'b1;
                     inject_ff <= 1'b0;
                  end else begin
                     status_ff <= ffaa_pkg::ST_OK;
                     inject_ff <= 1'b1;
                     state_ff <= SCAN;
                  end
               end else begin
                  inject_ff <= 1'b0;
                  if (rsp_valid_ff && rsp_bus.ready) rsp_valid_ff <= 1'b0;
               end
            end
            SCAN: begin
               inject_ff <= 1'b0;
               if (last_pkt.act) begin
                  if (!last_pkt.found) begin
                     state_ff <= FINISH;
                     status_ff <= bcast_ff.is_free ? ffaa_pkg::ST_UNKNOWN
                                                   : ffaa_pkg::ST_NO_FIT;
                  end else if (!bcast_ff.is_free) begin
                     state_ff <= FINISH;
                     if ({1'b0, last_pkt.size} >= split_need) begin
                        if (count_ff == CW'(MAX_SEGMENTS)) begin
                           status_ff <= ffaa_pkg::ST_FULL;
                        end else begin
                           bcast_ff.cmd <= ffaa_pkg::CELL_SPLIT;
                           bcast_ff.nstart <= last_pkt.start + W'(HEADER_BYTES) + bcast_ff.req;
                           bcast_ff.nsize <= last_pkt.size - W'(HEADER_BYTES) - bcast_ff.req;
                           count_ff <= count_ff + CW'(1);
                           payload_ff <= 12'(last_pkt.start + W'(HEADER_BYTES));
                        end
                     end else begin
                        bcast_ff.cmd <= ffaa_pkg::CELL_TAKE;
                        payload_ff <= 12'(last_pkt.start + W'(HEADER_BYTES));
                     end
                  end else begin
                     state_ff <= last_pkt.lf ? STEP2 : FINISH;
                     if (last_pkt.rf) begin
                        bcast_ff.cmd <= ffaa_pkg::CELL_MERGE_RIGHT;
                        count_ff <= count_ff - CW'(1);
                     end else begin
                        bcast_ff.cmd <= ffaa_pkg::CELL_MARK;
                     end
                  end
               end
            end
            STEP2: begin
               inject_ff <= 1'b0;
               bcast_ff.cmd <= ffaa_pkg::CELL_MERGE_LEFT;
               count_ff <= count_ff - CW'(1);
               state_ff <= FINISH;
            end
            FINISH: begin
               inject_ff <= 1'b0;
               bcast_ff.cmd <= ffaa_pkg::CELL_NONE;
               rsp_valid_ff <= 1'b1;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

// File: sv/ffaa_cell.sv
`timescale 1ns / 1ps
// One segment cell of the allocator chain: holds a segment, passes the search
// packet on, and shifts with its neighbors. Depends on ffaa_pkg.
module ffaa_cell #(
   parameter bit IS_HEAD      = 1'b0,
   parameter int ARENA_BYTES  = ffaa_pkg::ARENA_BYTES_DEF,
   parameter int HEADER_BYTES = ffaa_pkg::HEADER_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ffaa_pkg::bcast_type bcast,
   input  ffaa_pkg::pkt_type   pkt_in,
   output ffaa_pkg::pkt_type   pkt_out,
   input  ffaa_pkg::seg_type   left_seg,
   input  logic                left_sel,
   input  ffaa_pkg::seg_type   right_seg,
   input  logic                right_sel,
   output ffaa_pkg::seg_type   seg_out,
   output logic                sel_out
);

   localparam logic [ffaa_pkg::SEG_W-1:0] HDR = ffaa_pkg::SEG_W'(HEADER_BYTES);

   ffaa_pkg::seg_type seg_ff, seg_in;
   ffaa_pkg::pkt_type pkt_ff, pkt_in_d;
   logic              sel_ff, sel_in, after_ff, after_in;
   logic              match;
   logic [ffaa_pkg::SEG_W:0] hdr_pos;

   assign hdr_pos = {1'b0, seg_ff.start} + {1'b0, HDR};

   always_comb begin
      if (bcast.is_free) begin
         match = seg_ff.valid && !seg_ff.free &&
                 (hdr_pos == (ffaa_pkg::SEG_W+1)'(bcast.off));
      end else begin
         match = seg_ff.valid && seg_ff.free && (seg_ff.size >= bcast.req);
      end
   end

   always_comb begin
      pkt_in_d = pkt_in;
      pkt_in_d.prev_free = seg_ff.valid && seg_ff.free;
      pkt_in_d.just = 1'b0;
      sel_in = sel_ff;
      after_in = after_ff;
      if (pkt_in.act) begin
         if (pkt_in.search && match) begin
            sel_in = 1'b1;
            after_in = 1'b0;
            pkt_in_d.search = 1'b0;
            pkt_in_d.found = 1'b1;
            pkt_in_d.just = 1'b1;
            pkt_in_d.lf = pkt_in.prev_free;
            pkt_in_d.start = seg_ff.start;
            pkt_in_d.size = seg_ff.size;
         end else if (pkt_in.found) begin
            sel_in = 1'b0;
            after_in = 1'b1;
            if (pkt_in.just) begin
               pkt_in_d.rf = seg_ff.valid && seg_ff.free;
            end
         end else begin
            sel_in = 1'b0;
            after_in = 1'b0;
            pkt_in_d.search = pkt_in.search && seg_ff.valid;
         end
      end
   end

   always_comb begin
      seg_in = seg_ff;
      unique case (bcast.cmd)
         ffaa_pkg::CELL_SPLIT: begin
            if (left_sel) begin
               seg_in.valid = 1'b1;
               seg_in.free = 1'b1;
               seg_in.start = bcast.nstart;
               seg_in.size = bcast.nsize;
            end else if (after_ff) begin
               seg_in = left_seg;
            end else if (sel_ff) begin
               seg_in.size = bcast.req;
               seg_in.free = 1'b0;
            end
         end
         ffaa_pkg::CELL_TAKE: begin
            if (sel_ff) seg_in.free = 1'b0;
         end
         ffaa_pkg::CELL_MARK: begin
            if (sel_ff) seg_in.free = 1'b1;
         end
         ffaa_pkg::CELL_MERGE_RIGHT: begin
            if (sel_ff) begin
               seg_in.size = seg_ff.size + HDR + right_seg.size;
               seg_in.free = 1'b1;
            end else if (after_ff) begin
               seg_in = right_seg;
            end
         end
         ffaa_pkg::CELL_MERGE_LEFT: begin
            if (right_sel) begin
               seg_in.size = seg_ff.size + HDR + right_seg.size;
            end else if (sel_ff || after_ff) begin
               seg_in = right_seg;
            end
         end
         default: begin
            seg_in = seg_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff.valid <= IS_HEAD;
         seg_ff.free <= IS_HEAD;
         seg_ff.start <= '0;
         seg_ff.size <= IS_HEAD ? ffaa_pkg::SEG_W'(ARENA_BYTES - HEADER_BYTES) : '0;
         sel_ff <= 1'b0;
         after_ff <= 1'b0;
         pkt_ff <= '0;
      end else begin
         seg_ff <= seg_in;
         sel_ff <= sel_in;
         after_ff <= after_in;
         pkt_ff <= pkt_in_d;
      end
   end

   assign pkt_out = pkt_ff;
   assign seg_out = seg_ff;
   assign sel_out = sel_ff;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for first_fit_arena_allocator_top: a directed table, then random
// allocate and free traffic, each response checked against a segment-table predictor.
// Depends on ffaa_pkg, ffaa_if and the allocator RTL.
module testbench;

   localparam int ARENA = ffaa_pkg::ARENA_BYTES_DEF;
   localparam int HDR = ffaa_pkg::HEADER_BYTES_DEF;
   localparam int MSPLIT = ffaa_pkg::MIN_SPLIT_DEF;
   localparam int MAXSEG = ffaa_pkg::MAX_SEGMENTS_DEF;
   localparam int NUM_RANDOM = 1200;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      int unsigned start;
      int unsigned size;
      bit          is_free;
   } segment_type;

   typedef struct {
      logic [2:0]  status;
      logic [11:0] offset;
   } outcome_type;

   typedef struct {
      logic        cmd;
      logic [15:0] size;
      logic [11:0] offset;
      bit          typed;
      logic [2:0]  status;
      logic [11:0] payload;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   ffaa_req_if req_bus ();
   ffaa_rsp_if rsp_bus ();

   first_fit_arena_allocator_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   always #4 clock = ~clock;

   segment_type arena_map[$];
   outcome_type pending_outcomes[$];
   logic [11:0] live_offsets[$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          hold_off = 1'b0;

   task automatic report(input string what, input int got, input int want);
      $display("Mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   function automatic void arena_reset();
      segment_type s;
      arena_map.delete();
      s.start = 0;
      s.size = ARENA - HDR;
      s.is_free = 1'b1;
      arena_map.push_back(s);
   endfunction

   function automatic outcome_type arena_apply(input logic cmd, input int unsigned req,
                                               input int unsigned off);
      outcome_type r;
      segment_type s;
      int i;
      r.status = ffaa_pkg::ST_OK;
      r.offset = '0;
      if (cmd == ffaa_pkg::CMD_ALLOC) begin
         if (req == 0 || req > ARENA) begin
            r.status = ffaa_pkg::ST_BAD_SIZE;
            return r;
         end
         for (i = 0; i < arena_map.size(); i++)
            if (arena_map[i].is_free && arena_map[i].size >= req) break;
         if (i >= arena_map.size()) begin
            r.status = ffaa_pkg::ST_NO_FIT;
            return r;
         end
         if (arena_map[i].size >= req + HDR + MSPLIT) begin
            if (arena_map.size() >= MAXSEG) begin
               r.status = ffaa_pkg::ST_FULL;
               return r;
            end
            s.start = arena_map[i].start + HDR + req;
            s.size = arena_map[i].size - (HDR + req);
            s.is_free = 1'b1;
            arena_map.insert(i + 1, s);
            arena_map[i].size = req;
         end
         arena_map[i].is_free = 1'b0;
         r.offset = 12'(arena_map[i].start + HDR);
      end else begin
         if (off == 0) return r;
         for (i = 0; i < arena_map.size(); i++)
            if (!arena_map[i].is_free && arena_map[i].start + HDR == off) break;
         if (i >= arena_map.size()) begin
            r.status = ffaa_pkg::ST_UNKNOWN;
            return r;
         end
         arena_map[i].is_free = 1'b1;
         if (i + 1 < arena_map.size() && arena_map[i + 1].is_free) begin
            arena_map[i].size += HDR + arena_map[i + 1].size;
            arena_map.delete(i + 1);
         end
         if (i > 0 && arena_map[i - 1].is_free) begin
            arena_map[i - 1].size += HDR + arena_map[i].size;
            arena_map.delete(i);
         end
      end
      return r;
   endfunction

   task automatic send(input logic cmd, input logic [15:0] size, input logic [11:0] offset);
      outcome_type r;
      int gap;
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= cmd;
      req_bus.request_size <= size;
      req_bus.block_offset <= offset;
      do @(posedge clock); while (!req_bus.ready);
      r = arena_apply(cmd, size, offset);
      pending_outcomes.push_back(r);
      if (cmd == ffaa_pkg::CMD_ALLOC && r.status == ffaa_pkg::ST_OK)
         live_offsets.push_back(r.offset);
      if (cmd == ffaa_pkg::CMD_FREE)
         foreach (live_offsets[k])
            if (live_offsets[k] == offset && r.status == ffaa_pkg::ST_OK && offset != 0) begin
               live_offsets.delete(k);
               break;
            end
   endtask

   stim_row_type directed[$];

   function automatic void add_row(input logic cmd, input int size, input int offset,
                                   input bit typed, input logic [2:0] st, input int pay);
      stim_row_type row;
      row.cmd = cmd;
      row.size = 16'(size);
      row.offset = 12'(offset);
      row.typed = typed;
      row.status = st;
      row.payload = 12'(pay);
      directed.push_back(row);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int wait_left;
      wait_left = $urandom_range(0, 3);
      rsp_bus.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) wait_left = $urandom_range(0, 3);
         if (hold_off) begin
            rsp_bus.ready <= 1'b0;
         end else if (wait_left > 0) begin
            rsp_bus.ready <= 1'b0;
            wait_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_outcomes.size() == 0) begin
            report("unexpected transaction status", rsp_bus.status, -1);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_bus.status !== want.status)
               report("status", rsp_bus.status, want.status);
            if (rsp_bus.payload_offset !== want.offset)
               report("payload_offset", rsp_bus.payload_offset, want.offset);
         end
      end
   end

   initial begin
      int choice;
      int idx;
      req_bus.valid = 1'b0;
      req_bus.cmd = ffaa_pkg::CMD_ALLOC;
      req_bus.request_size = '0;
      req_bus.block_offset = '0;
      arena_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      add_row(ffaa_pkg::CMD_ALLOC, 0, 0, 1, ffaa_pkg::ST_BAD_SIZE, 0);
      add_row(ffaa_pkg::CMD_ALLOC, ARENA + 1, 0, 1, ffaa_pkg::ST_BAD_SIZE, 0);
      add_row(ffaa_pkg::CMD_ALLOC, 16'hFFFF, 12'hFFF, 1, ffaa_pkg::ST_BAD_SIZE, 0);
      add_row(ffaa_pkg::CMD_ALLOC, ARENA, 0, 1, ffaa_pkg::ST_NO_FIT, 0);
      add_row(ffaa_pkg::CMD_FREE, 0, 0, 1, ffaa_pkg::ST_OK, 0);
      add_row(ffaa_pkg::CMD_FREE, 16'hFFFF, 12'hFFF, 1, ffaa_pkg::ST_UNKNOWN, 0);
      add_row(ffaa_pkg::CMD_FREE, 0, HDR, 1, ffaa_pkg::ST_UNKNOWN, 0);
      add_row(ffaa_pkg::CMD_ALLOC, 1, 0, 1, ffaa_pkg::ST_OK, HDR);
      add_row(ffaa_pkg::CMD_ALLOC, 100, 0, 0, ffaa_pkg::ST_OK, 0);
      add_row(ffaa_pkg::CMD_FREE, 0, HDR, 1, ffaa_pkg::ST_OK, 0);
      add_row(ffaa_pkg::CMD_FREE, 0, HDR, 1, ffaa_pkg::ST_UNKNOWN, 0);
      add_row(ffaa_pkg::CMD_ALLOC, 8, 0, 0, ffaa_pkg::ST_OK, 0);
      add_row(ffaa_pkg::CMD_ALLOC, 4000, 0, 0, ffaa_pkg::ST_OK, 0);
      add_row(ffaa_pkg::CMD_FREE, 0, 25, 0, ffaa_pkg::ST_OK, 0);
      add_row(ffaa_pkg::CMD_ALLOC, 2, 0, 0, ffaa_pkg::ST_OK, 0);
      add_row(ffaa_pkg::CMD_FREE, 0, 33, 0, ffaa_pkg::ST_OK, 0);
      add_row(ffaa_pkg::CMD_ALLOC, ARENA - HDR, 0, 0, ffaa_pkg::ST_OK, 0);
      foreach (directed[i]) begin
         if (directed[i].typed) begin
            outcome_type probe;
            segment_type saved[$];
            saved = arena_map;
            probe = arena_apply(directed[i].cmd, directed[i].size, directed[i].offset);
            arena_map = saved;
            if (probe.status !== directed[i].status || probe.offset !== directed[i].payload)
               report("directed table row", i, probe.status);
         end
         send(directed[i].cmd, directed[i].size, directed[i].offset);
      end
      req_bus.valid <= 1'b0;
      wait (pending_outcomes.size() == 0);
      for (int k = live_offsets.size() - 1; k >= 0; k--)
         send(ffaa_pkg::CMD_FREE, '0, live_offsets[k]);
      live_offsets.delete();
      for (int k = 0; k < MAXSEG + 2; k++) send(ffaa_pkg::CMD_ALLOC, 16'(1), '0);

      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == NUM_RANDOM / 2) begin
            fork
               begin
                  hold_off = 1'b1;
                  repeat (400) @(posedge clock);
                  hold_off = 1'b0;
               end
            join_none
         end
         choice = $urandom_range(0, 99);
         if (choice < 45)
            send(ffaa_pkg::CMD_ALLOC,
                 16'($urandom_range(1, ($urandom_range(0, 7) == 0) ? 1500 : 96)),
                 12'($urandom));
         else if (choice < 85 && live_offsets.size() > 0) begin
            idx = $urandom_range(0, live_offsets.size() - 1);
            send(ffaa_pkg::CMD_FREE, 16'($urandom), live_offsets[idx]);
         end else if (choice < 92)
            send(ffaa_pkg::CMD_FREE, 16'($urandom), 12'($urandom));
         else if (choice < 96)
            send(ffaa_pkg::CMD_ALLOC, 16'($urandom_range(ARENA - 16, 65535)), 12'($urandom));
         else
            send(ffaa_pkg::CMD_FREE, 16'($urandom), '0);
      end

      req_bus.valid <= 1'b0;
      wait (pending_outcomes.size() == 0);
      repeat (2 * MAXSEG + 20) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
